@@ src/race_lap_timer_ring_defines.svh @@
`ifndef RACE_LAP_TIMER_RING_DEFINES_SVH
`define RACE_LAP_TIMER_RING_DEFINES_SVH

// same-cycle implication
`define RLTR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("race_lap_timer_ring: check failed");

// next-cycle implication
`define RLTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("race_lap_timer_ring: check failed");

`endif

@@ src/rltr_pkg.sv @@
package rltr_pkg;

  localparam int LAP_SLOTS = 16;
  localparam int SLOT_W    = $clog2(LAP_SLOTS);
  localparam int CNT_W     = $clog2(LAP_SLOTS + 1);

  localparam logic [31:0] INVALID_TS = 32'hFFFF_FFFF;
  localparam logic [31:0] DIV10_MUL  = 32'hCCCC_CCCD;

  localparam logic [1:0] REQ_TRIG  = 2'd0;
  localparam logic [1:0] REQ_STOP  = 2'd1;
  localparam logic [1:0] REQ_INVAL = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  localparam logic [1:0] OP_LAP    = 2'd0;
  localparam logic [1:0] OP_SINGLE = 2'd1;
  localparam logic [1:0] OP_MULTI  = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [1:0] CFG_OP_MODE     = 2'd0;
  localparam logic [1:0] CFG_SENSOR_MODE = 2'd1;
  localparam logic [1:0] CFG_MAX_RIDERS  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] event_time;
    logic [7:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic        lap_done;
    logic [3:0]  done_slot;
    logic [28:0] lap_ms;
    logic        run_started;
    logic [3:0]  started_slot;
    logic [4:0]  running_count;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_READ, ST_EXEC, ST_SKIP, ST_WR2, ST_FIN, ST_OUT
  } state_t;

endpackage

@@ src/race_lap_timer_ring.sv @@
// channel  | direction | handshake                   | payload
// request  | in        | start, busy                 | req (req_t)
// config   | in        | cfg_valid, cfg_ready        | cfg_index, cfg_data
// result   | out       | result_valid (one cycle)    | result (res_t)
//
// A request runs through the init, read, execute, optional second write, finish
// and output states while busy is high; the result follows with busy low. A stop
// in multi run mode runs skip in place of execute and walks past invalidated
// slots (up to 16 on each of up to two walks), one slot memory read per step.
// Reset is synchronous; the slot stores clear at once through per-entry valid
// bits. Results are never held off by the receiver; busy stays high until
// the result cycle, and configuration is taken only while idle.
`include "race_lap_timer_ring_defines.svh"

module race_lap_timer_ring (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  rltr_pkg::req_t       req,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 result_valid,
  output rltr_pkg::res_t       result
);

  localparam int SW = rltr_pkg::SLOT_W;
  localparam int CW = rltr_pkg::CNT_W;
  localparam int NS = rltr_pkg::LAP_SLOTS;

  rltr_pkg::state_t state, state_next;

  logic [1:0]  op_mode;
  logic        sens_mode;
  logic [4:0]  max_riders;

  rltr_pkg::req_t rq, rq_next;

  logic [SW-1:0] cur, cur_next, prev, prev_next, newest, newest_next, sslot, sslot_next;
  logic          cur_set, cur_set_next, newest_set, newest_set_next;
  logic          done_f, done_f_next, started_f, started_f_next, phase2, phase2_next;
  logic [CW-1:0] k, k_next;
  logic [31:0]   diff, diff_next, wr2_val, wr2_val_next;
  logic [63:0]   prod;

  logic [31:0]   start_mem [NS];
  logic [31:0]   end_mem   [NS];
  logic [NS-1:0] start_vld, end_vld;
  logic [31:0]   rs, re;

  logic          ws_en, we_en;
  logic [SW-1:0] ws_addr, we_addr;
  logic [31:0]   ws_data, we_data;

  logic lap_mode, single1, single2, multi;
  logic [SW-1:0] cur_inc, newest_inc, nx;
  logic [5:0]    mrun;
  logic [4:0]    running;
  logic          slot_ok, at_newest;

  assign lap_mode = (op_mode == rltr_pkg::OP_LAP) && !sens_mode;
  assign single1  = (op_mode == rltr_pkg::OP_SINGLE) && !sens_mode;
  assign single2  = (op_mode == rltr_pkg::OP_SINGLE) && sens_mode;
  assign multi    = (op_mode == rltr_pkg::OP_MULTI) && sens_mode;

  assign cur_inc    = (cur == SW'(NS - 1)) ? '0 : cur + SW'(1);
  assign newest_inc = (newest == SW'(NS - 1)) ? '0 : newest + SW'(1);
  assign nx         = newest_set ? newest_inc : '0;
  assign slot_ok    = (rs != rltr_pkg::INVALID_TS) && (re != rltr_pkg::INVALID_TS);
  assign at_newest  = newest_set && (cur == newest);

  always_comb begin
    if (!newest_set) begin
      mrun = '0;
    end else if (newest < cur) begin
      mrun = 6'(NS) - 6'(cur) + 6'(newest) + 6'd1;
    end else begin
      mrun = 6'(newest) - 6'(cur) + ((re == '0) ? 6'd1 : 6'd0);
    end
  end

  always_comb begin
    unique case (op_mode)
      rltr_pkg::OP_MULTI:  running = mrun[4:0];
      rltr_pkg::OP_LAP:    running = {4'd0, cur_set};
      rltr_pkg::OP_SINGLE: running = {4'd0, cur_set && (rs != '0) && (re == '0)};
      default:             running = '0;
    endcase
  end

  assign busy      = (state != rltr_pkg::ST_IDLE);
  assign cfg_ready = !busy;

  always_comb begin
    state_next      = state;
    rq_next         = rq;
    cur_next        = cur;
    cur_set_next    = cur_set;
    prev_next       = prev;
    newest_next     = newest;
    newest_set_next = newest_set;
    sslot_next      = sslot;
    done_f_next     = done_f;
    started_f_next  = started_f;
    phase2_next     = phase2;
    k_next          = k;
    diff_next       = diff;
    wr2_val_next    = wr2_val;
    ws_en = 1'b0; ws_addr = cur; ws_data = '0;
    we_en = 1'b0; we_addr = cur; we_data = '0;
    unique case (state)
      rltr_pkg::ST_IDLE: begin
        if (start) begin
          rq_next        = req;
          done_f_next    = 1'b0;
          started_f_next = 1'b0;
          sslot_next     = '0;
          phase2_next    = 1'b0;
          k_next         = '0;
          state_next     = rltr_pkg::ST_INIT;
        end
      end
      rltr_pkg::ST_INIT: begin
        if ((single1 || single2 || multi) && !cur_set) begin
          cur_next     = '0;
          cur_set_next = 1'b1;
          ws_en = 1'b1; ws_addr = '0; ws_data = '0;
        end
        state_next = rltr_pkg::ST_READ;
      end
      rltr_pkg::ST_READ: begin
        state_next = (rq.req_type == rltr_pkg::REQ_STOP && multi) ?
                     rltr_pkg::ST_SKIP : rltr_pkg::ST_EXEC;
      end
      rltr_pkg::ST_EXEC: begin
        state_next = rltr_pkg::ST_FIN;
        if (rq.req_type == rltr_pkg::REQ_INVAL) begin
          if (9'(rq.slot_index) < 9'(NS)) begin
            ws_en = 1'b1; ws_addr = rq.slot_index[SW-1:0]; ws_data = rltr_pkg::INVALID_TS;
            we_en = 1'b1; we_addr = rq.slot_index[SW-1:0]; we_data = rltr_pkg::INVALID_TS;
          end
        end else if (rq.req_type == rltr_pkg::REQ_TRIG && lap_mode) begin
          started_f_next = 1'b1;
          if (!cur_set) begin
            cur_next     = '0;
            cur_set_next = 1'b1;
            sslot_next   = '0;
            ws_en = 1'b1; ws_addr = '0; ws_data = rq.event_time;
          end else begin
            we_en = 1'b1; we_data = rq.event_time;
            done_f_next  = 1'b1;
            diff_next    = rq.event_time - rs;
            prev_next    = cur;
            cur_next     = cur_inc;
            sslot_next   = cur_inc;
            wr2_val_next = rq.event_time;
            state_next   = rltr_pkg::ST_WR2;
          end
        end else if ((rq.req_type == rltr_pkg::REQ_TRIG && single1 && re == '0 && rs != '0) ||
                     (rq.req_type == rltr_pkg::REQ_STOP && single2 && re == '0 && rs != '0)) begin
          we_en = 1'b1; we_data = rq.event_time;
          done_f_next  = 1'b1;
          diff_next    = rq.event_time - rs;
          prev_next    = cur;
          cur_next     = cur_inc;
          wr2_val_next = '0;
          state_next   = rltr_pkg::ST_WR2;
        end else if (rq.req_type == rltr_pkg::REQ_TRIG && (single1 || single2) && rs == '0) begin
          ws_en = 1'b1; ws_data = rq.event_time;
          we_en = 1'b1; we_data = '0;
          started_f_next = 1'b1;
          sslot_next     = cur;
        end else if (rq.req_type == rltr_pkg::REQ_TRIG && multi && (mrun[4:0] < max_riders)) begin
          ws_en = 1'b1; ws_addr = nx; ws_data = rq.event_time;
          we_en = 1'b1; we_addr = nx; we_data = '0;
          if (mrun == '0) begin
            cur_next = nx;
          end
          newest_next     = nx;
          newest_set_next = 1'b1;
          started_f_next  = 1'b1;
          sslot_next      = nx;
        end
      end
      rltr_pkg::ST_SKIP: begin
        if (slot_ok || at_newest || (k == CW'(NS))) begin
          state_next = rltr_pkg::ST_FIN;
          if (!phase2 && re == '0 && rs != '0) begin
            we_en = 1'b1; we_data = rq.event_time;
            done_f_next = 1'b1;
            diff_next   = rq.event_time - rs;
            prev_next   = cur;
            if (!at_newest) begin
              cur_next    = cur_inc;
              k_next      = '0;
              phase2_next = 1'b1;
              state_next  = rltr_pkg::ST_READ;
            end
          end
        end else begin
          cur_next   = cur_inc;
          k_next     = k + CW'(1);
          state_next = rltr_pkg::ST_READ;
        end
      end
      rltr_pkg::ST_WR2: begin
        ws_en = 1'b1; ws_data = wr2_val;
        state_next = rltr_pkg::ST_FIN;
      end
      rltr_pkg::ST_FIN: begin
        state_next = rltr_pkg::ST_OUT;
      end
      rltr_pkg::ST_OUT: begin
        state_next = rltr_pkg::ST_IDLE;
      end
      default: state_next = rltr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rltr_pkg::ST_IDLE;
      cur        <= '0;
      cur_set    <= 1'b0;
      prev       <= '0;
      newest     <= '0;
      newest_set <= 1'b0;
      op_mode    <= 2'd0;
      sens_mode  <= 1'b0;
      max_riders <= 5'd4;
      result_valid <= 1'b0;
      start_vld  <= '0;
      end_vld    <= '0;
    end else begin
      state      <= state_next;
      cur        <= cur_next;
      cur_set    <= cur_set_next;
      prev       <= prev_next;
      newest     <= newest_next;
      newest_set <= newest_set_next;
      result_valid <= (state == rltr_pkg::ST_OUT);
      if (ws_en) begin
        start_vld[ws_addr] <= 1'b1;
      end
      if (we_en) begin
        end_vld[we_addr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rltr_pkg::CFG_OP_MODE:     op_mode    <= cfg_data[1:0];
          rltr_pkg::CFG_SENSOR_MODE: sens_mode  <= cfg_data[0];
          rltr_pkg::CFG_MAX_RIDERS:  max_riders <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rq        <= rq_next;
    sslot     <= sslot_next;
    done_f    <= done_f_next;
    started_f <= started_f_next;
    phase2    <= phase2_next;
    k         <= k_next;
    diff      <= diff_next;
    wr2_val   <= wr2_val_next;
    prod      <= 64'(diff) * 64'(rltr_pkg::DIV10_MUL);
    if (ws_en) begin
      start_mem[ws_addr] <= ws_data;
    end
    if (we_en) begin
      end_mem[we_addr] <= we_data;
    end
    rs <= start_vld[cur] ? start_mem[cur] : '0;
    re <= end_vld[cur] ? end_mem[cur] : '0;
    if (state == rltr_pkg::ST_OUT) begin
      result.lap_done      <= done_f;
      result.done_slot     <= done_f ? 4'(prev) : 4'd0;
      result.lap_ms        <= done_f ? prod[63:35] : '0;
      result.run_started   <= started_f;
      result.started_slot  <= started_f ? 4'(sslot) : 4'd0;
      result.running_count <= running;
    end
  end

  `RLTR_ASSERT_NEXT(a_out_pulse, state == rltr_pkg::ST_OUT, result_valid && !busy)
  `RLTR_ASSERT_NEXT(a_single_pulse, result_valid, !result_valid)
  `RLTR_ASSERT_NOW(a_walk_bound, state == rltr_pkg::ST_SKIP, k <= CW'(NS))

endmodule
